// ===== rtl/hgc_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the gravity compensation force pipeline.
// No dependencies; imported by every module of the block.
package hgc_pkg;

    localparam int ANG_W = 18;
    localparam int SIN_W = 16;

    typedef logic signed [ANG_W-1:0] angle_t;
    typedef logic signed [SIN_W-1:0] sine_t;

    localparam int PI_Q13      = 25736;
    localparam int HALF_PI_Q13 = 12868;
    localparam int TWO_PI_Q13  = 51472;

    localparam int SIN_LAT       = 16;
    localparam int HORNER_STEPS  = 4;
    localparam logic [30:0] ONE_Q30 = 31'h4000_0000;
    localparam logic [30:0] SIN_ROUND = 31'h0000_8000;
    localparam logic [6:0]  HORNER_DIV [0:HORNER_STEPS-1] = '{7'd72, 7'd42, 7'd20, 7'd6};
    localparam logic [31:0] HORNER_MAGIC [0:HORNER_STEPS-1] =
        '{32'd3817748707, 32'd3272355082, 32'd3435973836, 32'd2863311530};
    localparam int HORNER_SHIFT [0:HORNER_STEPS-1] = '{38, 37, 36, 34};

    localparam logic signed [19:0] K_LIN2     = 20'sd468316;
    localparam logic signed [19:0] K_SHOULDER = 20'sd390888;
    localparam logic signed [17:0] K_ELBOW    = 18'sd80235;
    localparam logic [14:0]        DEN_K      = 15'd17694;
    localparam int ROUND14 = 8192;

    localparam int DEN_W = 29;
    localparam int QUO_W = 30;
    localparam int NP_W  = 44;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;
    localparam logic [CFG_IDX_W-1:0] CFG_FEEDBACK_ENABLE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SINGULAR_THRESHOLD = 2'd1;
    localparam logic [12:0] THR_RESET = 13'd82;

endpackage

// ===== rtl/hgc_sin.sv =====
`timescale 1ns / 1ps
// Pipelined Q13 angle to Q14 sine: range fold, then Horner cells of a degree-9 series.
// Depends on hgc_pkg.
module hgc_sin
    import hgc_pkg::*;
(
    input  logic   aclk,
    input  logic   en,
    input  angle_t angle,
    output sine_t  sine
);

    logic signed [18:0] a_ext, r1, r2;
    logic [18:0] m, mf;
    logic [13:0] mag_next, mag_reg;
    logic        neg1_reg;
    logic [30:0] x_s2;
    logic [61:0] sq;
    logic [31:0] x2_reg;
    logic [30:0] x2x_reg;
    logic        neg2_reg;

    logic [31:0] x2_w [0:HORNER_STEPS];
    logic [30:0] x_w  [0:HORNER_STEPS];
    logic [30:0] t_w  [0:HORNER_STEPS];
    logic        neg_w [0:HORNER_STEPS];

    logic [61:0] sp;
    logic [30:0] s_reg;
    logic        negf_reg;
    logic [30:0] rnd;
    sine_t       sine_reg;

    always_comb begin
        a_ext = 19'(angle);
        if (a_ext >= 19'(PI_Q13)) begin
            r1 = a_ext - 19'(TWO_PI_Q13);
        end else if (a_ext < -19'(PI_Q13)) begin
            r1 = a_ext + 19'(TWO_PI_Q13);
        end else begin
            r1 = a_ext;
        end
        r2 = (r1 < -19'(PI_Q13)) ? r1 + 19'(TWO_PI_Q13) : r1;
        m  = r2[18] ? 19'(-r2) : 19'(r2);
        mf = (m > 19'(HALF_PI_Q13)) ? 19'(PI_Q13) - m : m;
        mag_next = mf[13:0];
    end

    always_comb begin
        x_s2 = {mag_reg, 17'd0};
        sq   = 62'(x_s2) * 62'(x_s2);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            mag_reg  <= mag_next;
            neg1_reg <= r2[18];
            x2_reg   <= 32'(sq >> 30);
            x2x_reg  <= x_s2;
            neg2_reg <= neg1_reg;
        end
    end

    assign x2_w[0]  = x2_reg;
    assign x_w[0]   = x2x_reg;
    assign t_w[0]   = ONE_Q30;
    assign neg_w[0] = neg2_reg;

    for (genvar k = 0; k < HORNER_STEPS; k++) begin : g_step
        logic [62:0] pa;
        logic [63:0] pm;
        logic [39:0] r;
        logic [31:0] q;
        logic [31:0] pa_reg, pb_reg, qe_reg, x2a_reg, x2b_reg, x2c_reg;
        logic [30:0] xa_reg, xb_reg, xc_reg, t_reg;
        logic        nega_reg, negb_reg, negc_reg;

        always_comb begin
            pa = 63'(x2_w[k]) * 63'(t_w[k]);
            pm = 64'(pa_reg) * 64'(HORNER_MAGIC[k]);
            r  = 40'(pb_reg) - 40'(qe_reg) * 40'(HORNER_DIV[k]);
            q  = qe_reg + 32'(r >= 40'(HORNER_DIV[k]));
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                pa_reg   <= 32'(pa >> 30);
                x2a_reg  <= x2_w[k];
                xa_reg   <= x_w[k];
                nega_reg <= neg_w[k];
                qe_reg   <= 32'(pm >> HORNER_SHIFT[k]);
                pb_reg   <= pa_reg;
                x2b_reg  <= x2a_reg;
                xb_reg   <= xa_reg;
                negb_reg <= nega_reg;
                t_reg    <= ONE_Q30 - 31'(q);
                x2c_reg  <= x2b_reg;
                xc_reg   <= xb_reg;
                negc_reg <= negb_reg;
            end
        end

        assign x2_w[k+1]  = x2c_reg;
        assign x_w[k+1]   = xc_reg;
        assign t_w[k+1]   = t_reg;
        assign neg_w[k+1] = negc_reg;
    end

    always_comb begin
        sp  = 62'(x_w[HORNER_STEPS]) * 62'(t_w[HORNER_STEPS]);
        rnd = (s_reg + SIN_ROUND) >> 16;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s_reg    <= 31'(sp >> 30);
            negf_reg <= neg_w[HORNER_STEPS];
            sine_reg <= negf_reg ? -SIN_W'(rnd) : SIN_W'(rnd);
        end
    end

    assign sine = sine_reg;

    logic unused_x2;
    assign unused_x2 = |x2_w[HORNER_STEPS];

endmodule

// ===== rtl/hgc_div_cell.sv =====
`timescale 1ns / 1ps
// One restoring division cell: shift in a dividend bit, compare, subtract, emit a quotient bit.
// Depends on hgc_pkg.
module hgc_div_cell
    import hgc_pkg::*;
(
    input  logic             aclk,
    input  logic             en,
    input  logic [DEN_W-1:0] rem_in,
    input  logic [QUO_W-1:0] lowq_in,
    input  logic [DEN_W-1:0] den_in,
    output logic [DEN_W-1:0] rem_out,
    output logic [QUO_W-1:0] lowq_out,
    output logic [DEN_W-1:0] den_out
);

    logic [DEN_W:0]   trial;
    logic             ge;
    logic [DEN_W-1:0] rem_next;
    logic [DEN_W-1:0] rem_reg, den_reg;
    logic [QUO_W-1:0] lowq_reg;

    always_comb begin
        trial    = {rem_in, lowq_in[QUO_W-1]};
        ge       = trial >= {1'b0, den_in};
        rem_next = ge ? DEN_W'(trial - {1'b0, den_in}) : DEN_W'(trial);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg  <= rem_next;
            lowq_reg <= {lowq_in[QUO_W-2:0], ge};
            den_reg  <= den_in;
        end
    end

    assign rem_out  = rem_reg;
    assign lowq_out = lowq_reg;
    assign den_out  = den_reg;

endmodule

// ===== rtl/hgc_div.sv =====
`timescale 1ns / 1ps
// Divider as a chain of restoring cells, one quotient bit per cell and cycle while en is high.
// Depends on hgc_pkg and hgc_div_cell.
module hgc_div
    import hgc_pkg::*;
(
    input  logic             aclk,
    input  logic             en,
    input  logic [NP_W-1:0]  np,
    input  logic [DEN_W-1:0] den,
    output logic [QUO_W-1:0] quo
);

    logic [DEN_W-1:0] rem_w  [0:QUO_W];
    logic [QUO_W-1:0] lowq_w [0:QUO_W];
    logic [DEN_W-1:0] den_w  [0:QUO_W];

    assign rem_w[0]  = DEN_W'(np[NP_W-1:QUO_W]);
    assign lowq_w[0] = np[QUO_W-1:0];
    assign den_w[0]  = den;

    for (genvar i = 0; i < QUO_W; i++) begin : g_cell
        hgc_div_cell u_cell (
            .aclk     (aclk),
            .en       (en),
            .rem_in   (rem_w[i]),
            .lowq_in  (lowq_w[i]),
            .den_in   (den_w[i]),
            .rem_out  (rem_w[i+1]),
            .lowq_out (lowq_w[i+1]),
            .den_out  (den_w[i+1])
        );
    end

    assign quo = lowq_w[QUO_W];

    logic unused_tail;
    assign unused_tail = |{rem_w[QUO_W], den_w[QUO_W]};

endmodule

// ===== rtl/haptic_gravity_compensation_force.sv =====
`timescale 1ns / 1ps
// Top level: gravity compensation force of a three-link arm, fully pipelined.
// Depends on hgc_pkg, hgc_sin, hgc_div.
//
//   channel | handshake            | payload
//   --------+----------------------+-------------------------------------------
//   input   | s_valid / s_ready    | s_joint_base/shoulder/elbow, s_effort_x/y/z
//   result  | m_valid / m_ready    | m_force_x/y/z, m_singular, m_clipped
//   config  | cfg_valid/cfg_ready  | cfg_index, cfg_data
//
// One item per cycle while the output does not stall; an accepted item passes the input register,
// the 16-stage sine pipelines, six torque stages and the 30-cell divider chain before the output.
// Reset clears the pipeline valid bits, the output and skid valid flags and the config registers.
// With a result waiting and the skid register full, the pipeline holds and s_ready drops.
module haptic_gravity_compensation_force
    import hgc_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic signed [15:0]    s_joint_base,
    input  logic signed [15:0]    s_joint_shoulder,
    input  logic signed [15:0]    s_joint_elbow,
    input  logic signed [15:0]    s_effort_x,
    input  logic signed [15:0]    s_effort_y,
    input  logic signed [15:0]    s_effort_z,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic signed [15:0]    m_force_x,
    output logic signed [15:0]    m_force_y,
    output logic signed [15:0]    m_force_z,
    output logic                  m_singular,
    output logic                  m_clipped,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int PIPE_LEN = SIN_LAT + 7 + QUO_W;

    typedef struct packed {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] z;
    } effort_t;

    typedef struct packed {
        logic             sing;
        logic             s2neg;
        logic [DEN_W-1:0] den;
    } ctl_t;

    typedef struct packed {
        logic       sing;
        logic [2:0] neg;
    } side_t;

    typedef struct packed {
        logic signed [15:0] fx;
        logic signed [15:0] fy;
        logic signed [15:0] fz;
        logic               sing;
        logic               clip;
    } result_t;

    logic         fb_reg;
    logic [12:0]  thr_reg;
    logic         adv;
    logic [PIPE_LEN-1:0] vld_reg;

    angle_t             ang_next [0:6];
    angle_t             ang_reg  [0:6];
    logic signed [16:0] qm1m_next;
    logic signed [16:0] qm1m_reg [0:SIN_LAT];
    effort_t            eff_reg  [0:PIPE_LEN-1];
    sine_t              sn       [0:6];

    logic [15:0]        abs_s2;
    ctl_t               ctl_next;
    ctl_t               ctl_reg [0:5];
    logic signed [37:0] pk1_next, pk1_reg;
    logic signed [35:0] pk2_next, pk2_reg;
    logic signed [33:0] pk3_next, pk3_reg;
    sine_t c1_reg [0:1], s1_reg [0:1], c12_reg [0:1], s12_reg [0:1];
    sine_t s0_reg [0:3], c0_reg [0:3];

    logic signed [38:0] gsum;
    logic signed [34:0] esum;
    logic signed [23:0] g1_next, g1_reg;
    logic signed [19:0] g2_next, g2_reg;

    logic signed [24:0] gd, dg;
    logic signed [35:0] pb1_next, pb1_reg, pc2_next, pc2_reg;
    logic signed [40:0] pb2_next, pb2_reg, pc1_next, pc1_reg;

    logic signed [41:0] bsum, csum;
    logic signed [23:0] b_next, b_reg, c_next, c_reg;

    logic signed [39:0] n0_next, n0_reg, n2_next, n2_reg;
    logic signed [23:0] c5_reg;

    logic [39:0]      mag0, mag2;
    logic [23:0]      magc;
    logic [NP_W-1:0]  np_next [0:2];
    logic [NP_W-1:0]  np_reg  [0:2];
    side_t            side_next;
    side_t            side_reg [0:QUO_W];
    logic [QUO_W-1:0] quo [0:2];

    effort_t            eff_out;
    side_t              side_out;
    logic signed [32:0] f0, f1, f2;
    logic [16:0]        sat0, sat1, sat2;
    result_t            fin, main_reg, skid_reg;
    logic               m_valid_reg, skid_v_reg;

    function automatic logic [16:0] sat_force(input logic signed [32:0] v);
        logic [16:0] r;
        if (v > 33'sd32767) begin
            r = {1'b1, 16'h7fff};
        end else if (v < -33'sd32768) begin
            r = {1'b1, 16'h8000};
        end else begin
            r = {1'b0, v[15:0]};
        end
        return r;
    endfunction

    // configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fb_reg  <= 1'b0;
            thr_reg <= THR_RESET;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                CFG_FEEDBACK_ENABLE:    fb_reg  <= cfg_data[0];
                CFG_SINGULAR_THRESHOLD: thr_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // pipeline advance and valid bits
    assign adv     = ~skid_v_reg;
    assign s_ready = adv;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= {vld_reg[PIPE_LEN-2:0], s_valid};
        end
    end

    // input stage: DH angles and the seven sine arguments
    always_comb begin
        ang_next[0] = -ANG_W'(s_joint_base);
        ang_next[1] = -ANG_W'(s_joint_base) + ANG_W'(HALF_PI_Q13);
        ang_next[2] = ANG_W'(s_joint_shoulder);
        ang_next[3] = ANG_W'(s_joint_shoulder) + ANG_W'(HALF_PI_Q13);
        ang_next[4] = ANG_W'(s_joint_elbow) - ANG_W'(s_joint_shoulder) - ANG_W'(HALF_PI_Q13);
        ang_next[5] = ANG_W'(s_joint_elbow) - ANG_W'(HALF_PI_Q13);
        ang_next[6] = ANG_W'(s_joint_elbow);
        qm1m_next   = 17'(s_joint_shoulder) - 17'(HALF_PI_Q13);
    end

    for (genvar i = 0; i < 7; i++) begin : g_sin
        hgc_sin u_sin (
            .aclk  (aclk),
            .en    (adv),
            .angle (ang_reg[i]),
            .sine  (sn[i])
        );
    end

    // torque stages
    always_comb begin
        abs_s2        = sn[4][15] ? 16'(-sn[4]) : 16'(sn[4]);
        ctl_next.sing = (sn[4] == '0) || (abs_s2 < {2'b00, thr_reg, 1'b0});
        ctl_next.s2neg = sn[4][15];
        ctl_next.den  = DEN_W'(30'(abs_s2) * 30'(DEN_K));
        pk1_next = 38'(qm1m_reg[SIN_LAT]) * 38'(K_LIN2);
        pk2_next = 36'(sn[3]) * 36'(K_SHOULDER);
        pk3_next = 34'(sn[6]) * 34'(K_ELBOW);

        gsum    = 39'(pk1_reg) + 39'(pk2_reg) + 39'(pk3_reg) + 39'(ROUND14);
        esum    = 35'(pk3_reg) + 35'(ROUND14);
        g1_next = 24'(gsum >>> 14);
        g2_next = 20'(esum >>> 14);

        gd       = 25'(g1_reg) - 25'(g2_reg);
        dg       = 25'(g2_reg) - 25'(g1_reg);
        pb1_next = 36'(g2_reg) * 36'(c1_reg[1]);
        pb2_next = 41'(dg) * 41'(c12_reg[1]);
        pc1_next = 41'(s12_reg[1]) * 41'(gd);
        pc2_next = 36'(g2_reg) * 36'(s1_reg[1]);

        bsum   = 42'(pb1_reg) + 42'(pb2_reg) + 42'(ROUND14);
        csum   = 42'(pc1_reg) - 42'(pc2_reg) + 42'(ROUND14);
        b_next = 24'(bsum >>> 14);
        c_next = 24'(csum >>> 14);

        n0_next = 40'(s0_reg[3]) * 40'(b_reg);
        n2_next = 40'(c0_reg[3]) * 40'(b_reg);

        mag0 = n0_reg[39] ? 40'(-n0_reg) : 40'(n0_reg);
        mag2 = n2_reg[39] ? 40'(-n2_reg) : 40'(n2_reg);
        magc = c5_reg[23] ? 24'(-c5_reg) : 24'(c5_reg);
        np_next[0] = (NP_W'(mag0) << 7) + NP_W'(ctl_reg[4].den >> 1);
        np_next[1] = (NP_W'(magc) << 21) + NP_W'(ctl_reg[4].den >> 1);
        np_next[2] = (NP_W'(mag2) << 7) + NP_W'(ctl_reg[4].den >> 1);
        side_next.sing   = ctl_reg[4].sing;
        side_next.neg[0] = (n0_reg > 40'sd0) ^ ctl_reg[4].s2neg;
        side_next.neg[1] = c5_reg[23] ^ ctl_reg[4].s2neg;
        side_next.neg[2] = (n2_reg > 40'sd0) ^ ctl_reg[4].s2neg;
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            ang_reg     <= ang_next;
            qm1m_reg[0] <= qm1m_next;
            eff_reg[0]  <= '{x: s_effort_x, y: s_effort_y, z: s_effort_z};
            for (int i = 1; i <= SIN_LAT; i++) begin
                qm1m_reg[i] <= qm1m_reg[i-1];
            end
            for (int i = 1; i < PIPE_LEN; i++) begin
                eff_reg[i] <= eff_reg[i-1];
            end

            ctl_reg[0] <= ctl_next;
            for (int i = 1; i < 6; i++) begin
                ctl_reg[i] <= ctl_reg[i-1];
            end
            pk1_reg    <= pk1_next;
            pk2_reg    <= pk2_next;
            pk3_reg    <= pk3_next;
            c1_reg[0]  <= sn[3];
            s1_reg[0]  <= sn[2];
            c12_reg[0] <= sn[6];
            s12_reg[0] <= sn[5];
            c1_reg[1]  <= c1_reg[0];
            s1_reg[1]  <= s1_reg[0];
            c12_reg[1] <= c12_reg[0];
            s12_reg[1] <= s12_reg[0];
            s0_reg[0]  <= sn[0];
            c0_reg[0]  <= sn[1];
            for (int i = 1; i < 4; i++) begin
                s0_reg[i] <= s0_reg[i-1];
                c0_reg[i] <= c0_reg[i-1];
            end

            g1_reg  <= g1_next;
            g2_reg  <= g2_next;
            pb1_reg <= pb1_next;
            pb2_reg <= pb2_next;
            pc1_reg <= pc1_next;
            pc2_reg <= pc2_next;
            b_reg   <= b_next;
            c_reg   <= c_next;
            n0_reg  <= n0_next;
            n2_reg  <= n2_next;
            c5_reg  <= c_reg;
            np_reg  <= np_next;

            side_reg[0] <= side_next;
            for (int i = 1; i <= QUO_W; i++) begin
                side_reg[i] <= side_reg[i-1];
            end
        end
    end

    for (genvar i = 0; i < 3; i++) begin : g_div
        hgc_div u_div (
            .aclk (aclk),
            .en   (adv),
            .np   (np_reg[i]),
            .den  (ctl_reg[5].den),
            .quo  (quo[i])
        );
    end

    // sign, effort, saturation
    always_comb begin
        eff_out  = eff_reg[PIPE_LEN-1];
        side_out = side_reg[QUO_W];
        f0 = side_out.neg[0] ? -33'(quo[0]) : 33'(quo[0]);
        f1 = side_out.neg[1] ? -33'(quo[1]) : 33'(quo[1]);
        f2 = side_out.neg[2] ? -33'(quo[2]) : 33'(quo[2]);
        if (fb_reg) begin
            f0 = f0 + 33'(eff_out.x);
            f1 = f1 + 33'(eff_out.y);
            f2 = f2 + 33'(eff_out.z);
        end
        sat0 = sat_force(f0);
        sat1 = sat_force(f1);
        sat2 = sat_force(f2);
        if (side_out.sing) begin
            fin = '{fx: '0, fy: '0, fz: '0, sing: 1'b1, clip: 1'b0};
        end else begin
            fin = '{fx: sat0[15:0], fy: sat1[15:0], fz: sat2[15:0], sing: 1'b0,
                    clip: sat0[16] | sat1[16] | sat2[16]};
        end
    end

    // output register with skid stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            skid_v_reg  <= 1'b0;
        end else if (m_valid_reg && !m_ready) begin
            if (adv && vld_reg[PIPE_LEN-1]) begin
                skid_v_reg <= 1'b1;
            end
        end else begin
            m_valid_reg <= skid_v_reg | (adv & vld_reg[PIPE_LEN-1]);
            skid_v_reg  <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (m_valid_reg && !m_ready) begin
            if (adv) begin
                skid_reg <= fin;
            end
        end else begin
            main_reg <= skid_v_reg ? skid_reg : fin;
        end
    end

    assign m_valid    = m_valid_reg;
    assign m_force_x  = main_reg.fx;
    assign m_force_y  = main_reg.fy;
    assign m_force_z  = main_reg.fz;
    assign m_singular = main_reg.sing;
    assign m_clipped  = main_reg.clip;

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking bench for haptic_gravity_compensation_force: directed and random joint
// samples checked against an in-bench fixed-point force predictor. Depends on hgc_pkg.
module tb_top;
    import hgc_pkg::*;

    typedef struct packed {
        logic signed [15:0] fx;
        logic signed [15:0] fy;
        logic signed [15:0] fz;
        logic               sing;
        logic               clip;
    } force_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic signed [15:0] s_joint_base = '0, s_joint_shoulder = '0, s_joint_elbow = '0;
    logic signed [15:0] s_effort_x = '0, s_effort_y = '0, s_effort_z = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic signed [15:0] m_force_x, m_force_y, m_force_z;
    logic m_singular, m_clipped;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    force_t expected_forces[$];
    bit     fb_en = 1'b0;
    int     thr = 82;
    int     items_in = 0;
    int     cfg_writes = 0;
    int     tx_idle_pct = 0;
    int     rx_idle_pct = 0;
    int     rx_hold = 0;
    bit     failed = 1'b0;

    haptic_gravity_compensation_force u_top (.*);

    initial begin
        forever #4 aclk = ~aclk;
    end

    initial begin
        #3_000_000;
        $display("[haptic_gravity_compensation_force] ERROR");
        $finish;
    end

    function automatic int sin14(int a);
        bit neg;
        longint unsigned x, x2, t, s;
        neg = 1'b0;
        while (a >= PI_Q13) a -= TWO_PI_Q13;
        while (a < -PI_Q13) a += TWO_PI_Q13;
        if (a < 0) begin
            neg = 1'b1;
            a = -a;
        end
        if (a > HALF_PI_Q13) a = PI_Q13 - a;
        x = 64'(a) << 17;
        x2 = (x * x) >> 30;
        t = (64'd1 << 30) - x2 / 72;
        t = (64'd1 << 30) - ((x2 * t) >> 30) / 42;
        t = (64'd1 << 30) - ((x2 * t) >> 30) / 20;
        t = (64'd1 << 30) - ((x2 * t) >> 30) / 6;
        s = (x * t) >> 30;
        s = (s + 64'd32768) >> 16;
        return neg ? -int'(s) : int'(s);
    endfunction

    function automatic longint rnd14(longint v);
        return (v + 8192) >>> 14;
    endfunction

    function automatic longint quot_near(longint num, longint den);
        bit neg;
        longint unsigned n, d, q;
        neg = (num < 0) != (den < 0);
        n = num < 0 ? -num : num;
        d = den < 0 ? -den : den;
        q = (2 * n + d) / (2 * d);
        return neg ? -longint'(q) : longint'(q);
    endfunction

    function automatic force_t predict_force(int jb, int js, int je, int ex, int ey, int ez);
        force_t r;
        int q0, q1, q2, s2;
        longint c0, s0, c1, s1, c12, s12, g1, g2, b, c, den;
        longint f[3];
        int eff[3];
        q0 = -jb;
        q1 = js;
        q2 = je - js - HALF_PI_Q13;
        s2 = sin14(q2);
        eff = '{ex, ey, ez};
        r = '0;
        r.sing = (s2 == 0) || ((s2 < 0 ? -s2 : s2) < 2 * thr);
        if (!r.sing) begin
            c0 = sin14(q0 + HALF_PI_Q13);
            s0 = sin14(q0);
            c1 = sin14(q1 + HALF_PI_Q13);
            s1 = sin14(q1);
            c12 = sin14(q1 + q2 + HALF_PI_Q13);
            s12 = sin14(q1 + q2);
            g1 = rnd14(longint'(K_LIN2) * (q1 - HALF_PI_Q13) + longint'(K_SHOULDER) * c1
                       + longint'(K_ELBOW) * c12);
            g2 = rnd14(longint'(K_ELBOW) * c12);
            b = rnd14(g2 * c1 + (g2 - g1) * c12);
            c = rnd14(s12 * (g1 - g2) - g2 * s1);
            den = longint'(DEN_K) * s2 / 2;
            f[0] = quot_near(-(s0 * b) * 64, den);
            f[1] = quot_near(c * 16384 * 64, den);
            f[2] = quot_near(-(c0 * b) * 64, den);
            for (int i = 0; i < 3; i++) begin
                if (fb_en) f[i] += longint'(eff[i]);
                if (f[i] > 32767) begin
                    f[i] = 32767;
                    r.clip = 1'b1;
                end else if (f[i] < -32768) begin
                    f[i] = -32768;
                    r.clip = 1'b1;
                end
            end
            r.fx = f[0][15:0];
            r.fy = f[1][15:0];
            r.fz = f[2][15:0];
        end
        return r;
    endfunction

    // Track accepted items and register writes; predict at acceptance.
    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready) begin
            expected_forces.insert(expected_forces.size(),
                predict_force(int'(s_joint_base), int'(s_joint_shoulder),
                int'(s_joint_elbow), int'(s_effort_x), int'(s_effort_y),
                int'(s_effort_z)));
            items_in++;
        end
        if (aresetn && cfg_valid && cfg_ready) begin
            if (cfg_index == CFG_FEEDBACK_ENABLE) fb_en = cfg_data[0];
            else if (cfg_index == CFG_SINGULAR_THRESHOLD) thr = int'(cfg_data);
            cfg_writes++;
        end
    end

    always @(posedge aclk) begin
        force_t e;
        if (aresetn && m_valid && m_ready) begin
            if (expected_forces.size() == 0) begin
                $error("unexpected result item");
                failed = 1'b1;
            end else begin
                e = expected_forces.pop_front();
                if (m_force_x !== e.fx) begin
                    $error("force_x exp %0d got %0d", e.fx, m_force_x);
                    failed = 1'b1;
                end
                if (m_force_y !== e.fy) begin
                    $error("force_y exp %0d got %0d", e.fy, m_force_y);
                    failed = 1'b1;
                end
                if (m_force_z !== e.fz) begin
                    $error("force_z exp %0d got %0d", e.fz, m_force_z);
                    failed = 1'b1;
                end
                if (m_singular !== e.sing) begin
                    $error("singular exp %0b got %0b", e.sing, m_singular);
                    failed = 1'b1;
                end
                if (m_clipped !== e.clip) begin
                    $error("clipped exp %0b got %0b", e.clip, m_clipped);
                    failed = 1'b1;
                end
            end
        end
    end

    always @(negedge aclk) begin
        if (rx_hold > 0) begin
            m_ready <= 1'b0;
            rx_hold--;
        end else begin
            m_ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    task automatic send_item(int jb, int js, int je, int ex, int ey, int ez);
        int n;
        n = items_in;
        @(negedge aclk);
        if ($urandom_range(99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            do @(negedge aclk); while ($urandom_range(99) < tx_idle_pct);
        end
        s_valid <= 1'b1;
        s_joint_base <= 16'(jb);
        s_joint_shoulder <= 16'(js);
        s_joint_elbow <= 16'(je);
        s_effort_x <= 16'(ex);
        s_effort_y <= 16'(ey);
        s_effort_z <= 16'(ez);
        wait (items_in == n + 1);
    endtask

    task automatic drain();
        @(negedge aclk);
        s_valid <= 1'b0;
        wait (expected_forces.size() == 0);
        repeat (60) @(negedge aclk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        int n;
        n = cfg_writes;
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        wait (cfg_writes == n + 1);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    function automatic int rnd16();
        return int'($signed(16'($urandom)));
    endfunction

    task automatic send_random(int count, int near_pct);
        int js, je;
        for (int i = 0; i < count; i++) begin
            js = rnd16();
            if ($urandom_range(99) < near_pct)
                je = int'($signed(16'(js + HALF_PI_Q13 + $urandom_range(600) - 300)));
            else
                je = rnd16();
            send_item(rnd16(), js, je, rnd16(), rnd16(), rnd16());
        end
    endtask

    task automatic test_directed();
        int ext[3];
        ext = '{0, 32767, -32768};
        foreach (ext[a]) foreach (ext[b])
            send_item(ext[a], ext[b], ext[(a + b) % 3], ext[a], ext[b], ext[(a + 1) % 3]);
        // Hold elbow sine at zero and near zero.
        send_item(100, 2000, 2000 + HALF_PI_Q13, 0, 0, 0);
        send_item(-100, -4000, -4000 + HALF_PI_Q13 + PI_Q13, 5, 5, 5);
        send_item(0, 1000, 1000 + HALF_PI_Q13 + 80, 0, 0, 0);
        drain();
    endtask

    task automatic test_register_writes();
        write_reg(CFG_FEEDBACK_ENABLE, 13'd1);
        write_reg(CFG_SINGULAR_THRESHOLD, 13'd0);
        send_item(3000, 1000, 1000 + HALF_PI_Q13 + 3, 32767, -32768, 32767);
        send_item(-3000, -1000, -1000 + HALF_PI_Q13 - 2, -32768, 32767, -32768);
        send_item(0, 0, HALF_PI_Q13 + 1, 32767, 32767, 32767);
        send_item(1, 1, 1 + HALF_PI_Q13, 1, 1, 1);
        drain();
        // Drop upper bits, ignore unused indexes.
        write_reg(CFG_FEEDBACK_ENABLE, 13'h1FFE);
        write_reg(2'd2, 13'h1FFF);
        write_reg(2'd3, 13'h0);
        write_reg(CFG_SINGULAR_THRESHOLD, 13'd8191);
        send_random(10, 20);
        send_item(0, 0, 0, 100, 100, 100);
        drain();
    endtask

    task automatic test_random_phase(int tx_pct, int rx_pct, bit fb, int th, int count);
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        write_reg(CFG_FEEDBACK_ENABLE, CFG_DATA_W'(fb));
        write_reg(CFG_SINGULAR_THRESHOLD, CFG_DATA_W'(th));
        send_random(count, 30);
        drain();
    endtask

    task automatic test_backpressure();
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        rx_hold = 300;
        send_random(150, 30);
        drain();
    endtask

    initial begin
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        test_directed();
        test_register_writes();
        test_random_phase(15, 59, 1'b1, 82, 600);
        test_random_phase(59, 15, 1'b0, $urandom_range(1, 400), 600);
        test_random_phase(0, 0, 1'b1, 0, 450);
        test_backpressure();
        if (!failed)
            $display("[haptic_gravity_compensation_force] OK");
        else
            $display("[haptic_gravity_compensation_force] ERROR");
        $finish;
    end
endmodule
